[rtl/bpa_pkg.sv]
`default_nettype none
package bpa_pkg;

  // default geometry
  localparam int BPA_NUM_PAGES     = 4096;
  localparam int BPA_LEVELS        = 13;
  localparam int BPA_PAGE_SIZE_LOG = 12;

  // fixed port widths
  localparam int CFG_W    = 13;
  localparam int OPC_W    = 2;
  localparam int SLOG_W   = 5;
  localparam int BYTE_W   = 25;
  localparam int PAGE_W   = 12;
  localparam int STATUS_W = 2;
  localparam int TAG_W    = 3;

  localparam logic [OPC_W-1:0] OP_ALLOC_LOG   = 2'd0;
  localparam logic [OPC_W-1:0] OP_ALLOC_BYTES = 2'd1;
  localparam logic [OPC_W-1:0] OP_FREE        = 2'd2;
  localparam logic [OPC_W-1:0] OP_INIT        = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd2;

  localparam logic [TAG_W-1:0] TAG_UNUSABLE   = 3'd0;
  localparam logic [TAG_W-1:0] TAG_FREE       = 3'd1;
  localparam logic [TAG_W-1:0] TAG_PART       = 3'd2;
  localparam logic [TAG_W-1:0] TAG_ALLOC      = 3'd3;
  localparam logic [TAG_W-1:0] TAG_PART_ALLOC = 3'd4;

endpackage
`default_nettype wire

[rtl/bpa_ram.sv]
`default_nettype none
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/bpa_blk_size.sv]
`default_nettype none
module bpa_blk_size #(
  parameter int LEVELS = 13,
  parameter int EW     = 14
) (
  input  wire logic [EW-1:0]             pg,
  input  wire logic [EW-1:0]             end_pg,
  output logic      [$clog2(LEVELS)-1:0] k,
  output logic      [EW-1:0]             size
);

  localparam int LVW = $clog2(LEVELS);

  logic [EW-1:0] sz;

  // largest aligned block starting at pg that still fits below end_pg
  always_comb begin
    k    = '0;
    size = EW'(1);
    sz   = EW'(1);
    for (int i = 1; i < LEVELS; i++) begin
      sz = EW'(1) << i;
      if (((pg & (sz - EW'(1))) == '0) &&
          (({1'b0, pg} + {1'b0, sz}) <= {1'b0, end_pg})) begin
        k    = LVW'(i);
        size = sz;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/buddy_page_allocator_core.sv]
`default_nettype none
// channel  | ports                                            | handshake
// ---------+--------------------------------------------------+--------------------------
// request  | in_opcode in_size_log in_byte_size in_page_index | start while busy is low
// result   | out_block_page out_status                        | out_valid, one cycle
// config   | cfg_pool_pages                                   | cfg_wr_en, any cycle idle
//
// steps: every step goes through simple dual-port page rams (tag, level, count, links),
// one write and one read port each. alloc pops the smallest fitting block and splits it
// level by level; with no block found it runs a merge pass over the free lists and tries again.
// free reads the block, may carve its tail and pushes it; carving writes one tag per page.
// init sweeps all NUM_PAGES tags once, carving the pool into blocks.
// reset empties the list heads but not the page rams; page state is unknown until the first init.
// one beat is taken at a time; the result beat shows in the cycle busy falls.
module buddy_page_allocator_core
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES     = BPA_NUM_PAGES,
  parameter int LEVELS        = BPA_LEVELS,
  parameter int PAGE_SIZE_LOG = BPA_PAGE_SIZE_LOG
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [OPC_W-1:0]    in_opcode,
  input  wire logic [SLOG_W-1:0]   in_size_log,
  input  wire logic [BYTE_W-1:0]   in_byte_size,
  input  wire logic [PAGE_W-1:0]   in_page_index,
  output logic                     out_valid,
  output logic [PAGE_W-1:0]        out_block_page,
  output logic [STATUS_W-1:0]      out_status,
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_W-1:0]    cfg_pool_pages
);

  localparam int PW  = $clog2(NUM_PAGES);
  localparam int AW  = PW + 1;
  localparam int LVW = $clog2(LEVELS);
  localparam int CW  = LEVELS;
  localparam int EW  = ((PW > LEVELS) ? PW : LEVELS) + 1;
  localparam int PGW = BYTE_W - PAGE_SIZE_LOG + 1;
  localparam logic [AW-1:0] NIL = AW'(NUM_PAGES);

  typedef enum logic [4:0] {
    S_IDLE, S_FIN,
    S_AL_START, S_AL_SPLIT, S_AL_C2,
    S_FR_RD, S_FR_CHK, S_FR_HALF, S_FR_PUSH,
    S_IN_HEADS, S_IN_CLR,
    S_CV_HEAD, S_CV_BODY,
    S_PU0, S_PU1, S_UL0, S_UL1,
    S_MG_LVL, S_MG_CUR, S_MG_RD, S_MG_CHK, S_MG_NB, S_MG_U2, S_MG_FIN
  } state_t;

  state_t state_r, state_nxt, sub_ret_r, sub_ret_nxt, cv_ret_r, cv_ret_nxt;

  logic [OPC_W-1:0]    op_r, op_nxt;
  logic [LVW-1:0]      req_r, req_nxt;
  logic [CW-1:0]       pages_r, pages_nxt;
  logic                partial_r, partial_nxt;
  logic [PW-1:0]       p_r, p_nxt;
  logic [LVW-1:0]      k_r, k_nxt;
  logic                merged_r, merged_nxt;
  logic [PW-1:0]       sp_pg_r, sp_pg_nxt;
  logic [LVW-1:0]      sp_lvl_r, sp_lvl_nxt;
  logic [AW-1:0]       h_r, h_nxt;
  logic [PW-1:0]       ul_pg_r, ul_pg_nxt;
  logic [LVW-1:0]      ul_lvl_r, ul_lvl_nxt;
  logic [EW-1:0]       cv_pg_r, cv_pg_nxt, cv_end_r, cv_end_nxt, cv_stop_r, cv_stop_nxt;
  logic [TAG_W-1:0]    cv_first_r, cv_first_nxt, cv_rest_r, cv_rest_nxt;
  logic [AW-1:0]       cur_r, cur_nxt, nxt_r, nxt_nxt;
  logic [LVW-1:0]      fr_lvl_r, fr_lvl_nxt;
  logic [CW-1:0]       fr_used_r, fr_used_nxt;
  logic [PAGE_W-1:0]   res_page_r, res_page_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0]    pool_r;
  logic [AW-1:0]       head_r [LEVELS];

  // ram ports
  logic             tag_we, lvl_we, used_we, nx_we, pv_we;
  logic [PW-1:0]    tag_waddr, lvl_waddr, used_waddr, nx_waddr, pv_waddr;
  logic [PW-1:0]    tag_raddr, lvl_raddr, used_raddr, nx_raddr, pv_raddr;
  logic [TAG_W-1:0] tag_wdata, tag_rdata;
  logic [LVW-1:0]   lvl_wdata, lvl_rdata;
  logic [CW-1:0]    used_wdata, used_rdata;
  logic [AW-1:0]    nx_wdata, nx_rdata, pv_wdata, pv_rdata;

  // list head access
  logic           hd_we, hd_clr;
  logic [LVW-1:0] hd_widx, hd_idx;
  logic [AW-1:0]  hd_wdata, hd_rd;

  // helpers
  logic [EW-1:0]      pool_end, bud, lo, hi, half, cap_e;
  logic               fn_found;
  logic [LVW-1:0]     fn_k, cv_k, lv;
  logic [EW-1:0]      cv_size;
  logic [5:0]         rq6, blvl, lv6;
  logic [BYTE_W:0]    bsum;
  logic [PGW-1:0]     pg_cnt;
  logic [CW-1:0]      cap;

  bpa_ram #(.WIDTH(TAG_W), .DEPTH(NUM_PAGES)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .raddr(tag_raddr), .rdata(tag_rdata));
  bpa_ram #(.WIDTH(LVW), .DEPTH(NUM_PAGES)) u_lvl (
    .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(lvl_raddr), .rdata(lvl_rdata));
  bpa_ram #(.WIDTH(CW), .DEPTH(NUM_PAGES)) u_used (
    .clk(clk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
    .raddr(used_raddr), .rdata(used_rdata));
  bpa_ram #(.WIDTH(AW), .DEPTH(NUM_PAGES)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata));
  bpa_ram #(.WIDTH(AW), .DEPTH(NUM_PAGES)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(pv_raddr), .rdata(pv_rdata));

  bpa_blk_size #(.LEVELS(LEVELS), .EW(EW)) u_blk (
    .pg(cv_pg_r), .end_pg(cv_end_r), .k(cv_k), .size(cv_size));

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_block_page = res_page_r;
  assign out_status     = res_status_r;

  assign pool_end = (int'(pool_r) > NUM_PAGES) ? EW'(NUM_PAGES) : EW'(pool_r);

  function automatic logic [EW-1:0] clamp_end(input logic [EW-1:0] e);
    clamp_end = (int'(e) > NUM_PAGES) ? EW'(NUM_PAGES) : e;
  endfunction

  // smallest non-empty level at or above the request
  always_comb begin
    fn_found = 1'b0;
    fn_k     = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if ((i >= int'(req_r)) && (head_r[i] != NIL)) begin
        fn_found = 1'b1;
        fn_k     = LVW'(i);
      end
    end
  end

  always_comb begin
    case (state_r)
      S_PU0:    hd_idx = sp_lvl_r;
      S_UL1:    hd_idx = ul_lvl_r;
      S_MG_LVL: hd_idx = k_r;
      default:  hd_idx = fn_k;
    endcase
  end
  assign hd_rd = head_r[hd_idx];

  // request decode
  always_comb begin
    rq6  = (int'(in_size_log) < PAGE_SIZE_LOG) ? 6'd0 : 6'(int'(in_size_log) - PAGE_SIZE_LOG);
    bsum = {1'b0, in_byte_size} + (BYTE_W + 1)'((1 << PAGE_SIZE_LOG) - 1);
    pg_cnt = PGW'(bsum >> PAGE_SIZE_LOG);
    if (pg_cnt == '0) begin
      pg_cnt = PGW'(1);
    end
    blvl = '0;
    for (int l = PGW; l >= 0; l--) begin
      if ({1'b0, pg_cnt} <= ((PGW + 1)'(1) << l)) begin
        blvl = 6'(l);
      end
    end
    lv6 = (in_opcode == OP_ALLOC_BYTES) ? blvl : rq6;
  end

  assign bud  = EW'(cur_r) ^ (EW'(1) << k_r);
  assign lo   = (EW'(cur_r) < bud) ? EW'(cur_r) : bud;
  assign hi   = (EW'(cur_r) < bud) ? bud : EW'(cur_r);
  assign lv   = (int'(lvl_rdata) > LEVELS - 1) ? LVW'(LEVELS - 1) : lvl_rdata;
  assign cap  = CW'(1) << lv;
  assign half = EW'(p_r) + (EW'(1) << (fr_lvl_r - LVW'(1)));
  assign cap_e = EW'(p_r) + (EW'(1) << (lv - LVW'(1)));

  always_comb begin
    state_nxt      = state_r;
    sub_ret_nxt    = sub_ret_r;
    cv_ret_nxt     = cv_ret_r;
    op_nxt         = op_r;
    req_nxt        = req_r;
    pages_nxt      = pages_r;
    partial_nxt    = partial_r;
    p_nxt          = p_r;
    k_nxt          = k_r;
    merged_nxt     = merged_r;
    sp_pg_nxt      = sp_pg_r;
    sp_lvl_nxt     = sp_lvl_r;
    h_nxt          = h_r;
    ul_pg_nxt      = ul_pg_r;
    ul_lvl_nxt     = ul_lvl_r;
    cv_pg_nxt      = cv_pg_r;
    cv_end_nxt     = cv_end_r;
    cv_stop_nxt    = cv_stop_r;
    cv_first_nxt   = cv_first_r;
    cv_rest_nxt    = cv_rest_r;
    cur_nxt        = cur_r;
    nxt_nxt        = nxt_r;
    fr_lvl_nxt     = fr_lvl_r;
    fr_used_nxt    = fr_used_r;
    res_page_nxt   = res_page_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = 1'b0;

    tag_we = 1'b0; tag_waddr = '0; tag_wdata = '0; tag_raddr = '0;
    lvl_we = 1'b0; lvl_waddr = '0; lvl_wdata = '0; lvl_raddr = '0;
    used_we = 1'b0; used_waddr = '0; used_wdata = '0; used_raddr = '0;
    nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0; nx_raddr = '0;
    pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0; pv_raddr = '0;
    hd_we = 1'b0; hd_widx = '0; hd_wdata = '0; hd_clr = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt         = in_opcode;
          res_page_nxt   = '0;
          res_status_nxt = ST_OK;
          req_nxt        = LVW'(lv6);
          pages_nxt      = CW'(pg_cnt);
          partial_nxt    = ({1'b0, pg_cnt} != ((PGW + 1)'(1) << blvl));
          merged_nxt     = 1'b0;
          p_nxt          = PW'(in_page_index);
          case (in_opcode)
            OP_ALLOC_LOG, OP_ALLOC_BYTES: begin
              if (int'(lv6) >= LEVELS) begin
                res_status_nxt = ST_TOO_BIG;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_AL_START;
              end
            end
            OP_FREE: begin
              state_nxt = (int'(in_page_index) >= NUM_PAGES) ? S_FIN : S_FR_RD;
            end
            default: state_nxt = S_IN_HEADS;
          endcase
        end
      end

      S_FIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      // ---- alloc
      S_AL_START: begin
        if (!fn_found) begin
          if (merged_r) begin
            res_status_nxt = ST_NO_BLOCK;
            state_nxt      = S_FIN;
          end else begin
            merged_nxt = 1'b1;
            k_nxt      = '0;
            state_nxt  = S_MG_LVL;
          end
        end else begin
          k_nxt       = fn_k;
          p_nxt       = PW'(hd_rd);
          ul_pg_nxt   = PW'(hd_rd);
          ul_lvl_nxt  = fn_k;
          sub_ret_nxt = S_AL_SPLIT;
          state_nxt   = S_UL0;
        end
      end

      S_AL_SPLIT: begin
        if (k_r > req_r) begin
          // upper half goes back one level down
          sp_pg_nxt   = p_r + (PW'(1) << (k_r - LVW'(1)));
          sp_lvl_nxt  = k_r - LVW'(1);
          tag_we      = 1'b1;
          tag_waddr   = sp_pg_nxt;
          tag_wdata   = TAG_FREE;
          lvl_we      = 1'b1;
          lvl_waddr   = sp_pg_nxt;
          lvl_wdata   = sp_lvl_nxt;
          k_nxt       = k_r - LVW'(1);
          sub_ret_nxt = S_AL_SPLIT;
          state_nxt   = S_PU0;
        end else begin
          tag_we       = 1'b1;
          tag_waddr    = p_r;
          tag_wdata    = TAG_ALLOC;
          lvl_we       = 1'b1;
          lvl_waddr    = p_r;
          lvl_wdata    = req_r;
          used_we      = 1'b1;
          used_waddr   = p_r;
          used_wdata   = (op_r == OP_ALLOC_BYTES) ? pages_r : (CW'(1) << req_r);
          res_page_nxt = PAGE_W'(p_r);
          if ((op_r == OP_ALLOC_BYTES) && partial_r) begin
            // pages in use past the lower half are tagged as partly allocated
            cv_pg_nxt    = EW'(p_r) + (EW'(1) << (req_r - LVW'(1)));
            cv_end_nxt   = clamp_end(EW'(p_r) + EW'(pages_r));
            cv_first_nxt = TAG_PART_ALLOC;
            cv_rest_nxt  = TAG_PART_ALLOC;
            cv_ret_nxt   = S_AL_C2;
            state_nxt    = S_CV_HEAD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_AL_C2: begin
        cv_pg_nxt    = EW'(p_r) + EW'(pages_r);
        cv_end_nxt   = clamp_end(EW'(p_r) + (EW'(1) << req_r));
        cv_first_nxt = TAG_FREE;
        cv_rest_nxt  = TAG_PART;
        cv_ret_nxt   = S_FIN;
        state_nxt    = S_CV_HEAD;
      end

      // ---- free
      S_FR_RD: begin
        tag_raddr  = p_r;
        lvl_raddr  = p_r;
        used_raddr = p_r;
        state_nxt  = S_FR_CHK;
      end

      S_FR_CHK: begin
        if (tag_rdata != TAG_ALLOC) begin
          state_nxt = S_FIN;
        end else begin
          fr_lvl_nxt  = lv;
          fr_used_nxt = (used_rdata > cap) ? cap : used_rdata;
          if ((lv != '0) && (int'(cap_e) < NUM_PAGES)) begin
            tag_raddr = PW'(cap_e);
            state_nxt = S_FR_HALF;
          end else begin
            state_nxt = S_FR_PUSH;
          end
        end
      end

      S_FR_HALF: begin
        if (tag_rdata == TAG_PART_ALLOC) begin
          fr_lvl_nxt   = fr_lvl_r - LVW'(1);
          lvl_we       = 1'b1;
          lvl_waddr    = p_r;
          lvl_wdata    = fr_lvl_r - LVW'(1);
          cv_pg_nxt    = half;
          cv_end_nxt   = clamp_end(EW'(p_r) + EW'(fr_used_r));
          cv_first_nxt = TAG_FREE;
          cv_rest_nxt  = TAG_PART;
          cv_ret_nxt   = S_FR_PUSH;
          state_nxt    = S_CV_HEAD;
        end else begin
          state_nxt = S_FR_PUSH;
        end
      end

      S_FR_PUSH: begin
        tag_we      = 1'b1;
        tag_waddr   = p_r;
        tag_wdata   = TAG_FREE;
        sp_pg_nxt   = p_r;
        sp_lvl_nxt  = fr_lvl_r;
        sub_ret_nxt = S_FIN;
        state_nxt   = S_PU0;
      end

      // ---- init
      S_IN_HEADS: begin
        hd_clr       = 1'b1;
        cv_pg_nxt    = '0;
        cv_end_nxt   = pool_end;
        cv_first_nxt = TAG_FREE;
        cv_rest_nxt  = TAG_PART;
        cv_ret_nxt   = S_IN_CLR;
        state_nxt    = S_CV_HEAD;
      end

      S_IN_CLR: begin
        // pages past the pool become unusable
        if (int'(cv_pg_r) >= NUM_PAGES) begin
          state_nxt = S_FIN;
        end else begin
          tag_we    = 1'b1;
          tag_waddr = PW'(cv_pg_r);
          tag_wdata = TAG_UNUSABLE;
          cv_pg_nxt = cv_pg_r + EW'(1);
        end
      end

      // ---- carve [cv_pg, cv_end) into maximal aligned blocks
      S_CV_HEAD: begin
        if (cv_pg_r >= cv_end_r) begin
          state_nxt = cv_ret_r;
        end else begin
          tag_we      = 1'b1;
          tag_waddr   = PW'(cv_pg_r);
          tag_wdata   = cv_first_r;
          lvl_we      = 1'b1;
          lvl_waddr   = PW'(cv_pg_r);
          lvl_wdata   = cv_k;
          cv_stop_nxt = cv_pg_r + cv_size;
          cv_pg_nxt   = cv_pg_r + EW'(1);
          if (cv_first_r == TAG_FREE) begin
            sp_pg_nxt   = PW'(cv_pg_r);
            sp_lvl_nxt  = cv_k;
            sub_ret_nxt = S_CV_BODY;
            state_nxt   = S_PU0;
          end else begin
            state_nxt = S_CV_BODY;
          end
        end
      end

      S_CV_BODY: begin
        if (cv_pg_r == cv_stop_r) begin
          state_nxt = S_CV_HEAD;
        end else begin
          tag_we    = 1'b1;
          tag_waddr = PW'(cv_pg_r);
          tag_wdata = cv_rest_r;
          cv_pg_nxt = cv_pg_r + EW'(1);
        end
      end

      // ---- push sp_pg onto list sp_lvl
      S_PU0: begin
        nx_we    = 1'b1;
        nx_waddr = sp_pg_r;
        nx_wdata = hd_rd;
        pv_we    = 1'b1;
        pv_waddr = sp_pg_r;
        pv_wdata = NIL;
        hd_we    = 1'b1;
        hd_widx  = sp_lvl_r;
        hd_wdata = AW'(sp_pg_r);
        h_nxt    = hd_rd;
        state_nxt = (hd_rd != NIL) ? S_PU1 : sub_ret_r;
      end

      S_PU1: begin
        pv_we     = 1'b1;
        pv_waddr  = PW'(h_r);
        pv_wdata  = AW'(sp_pg_r);
        state_nxt = sub_ret_r;
      end

      // ---- unlink ul_pg from list ul_lvl
      S_UL0: begin
        nx_raddr  = ul_pg_r;
        pv_raddr  = ul_pg_r;
        state_nxt = S_UL1;
      end

      S_UL1: begin
        if (pv_rdata == NIL) begin
          hd_we    = 1'b1;
          hd_widx  = ul_lvl_r;
          hd_wdata = nx_rdata;
        end else begin
          nx_we    = 1'b1;
          nx_waddr = PW'(pv_rdata);
          nx_wdata = nx_rdata;
        end
        if (nx_rdata != NIL) begin
          pv_we    = 1'b1;
          pv_waddr = PW'(nx_rdata);
          pv_wdata = pv_rdata;
        end
        state_nxt = sub_ret_r;
      end

      // ---- lazy merge, smallest level first
      S_MG_LVL: begin
        cur_nxt   = hd_rd;
        state_nxt = S_MG_CUR;
      end

      S_MG_CUR: begin
        if (cur_r == NIL) begin
          if (int'(k_r) >= LEVELS - 2) begin
            state_nxt = S_AL_START;
          end else begin
            k_nxt     = k_r + LVW'(1);
            state_nxt = S_MG_LVL;
          end
        end else begin
          state_nxt = S_MG_RD;
        end
      end

      S_MG_RD: begin
        nx_raddr  = PW'(cur_r);
        tag_raddr = PW'(bud);
        lvl_raddr = PW'(bud);
        state_nxt = S_MG_CHK;
      end

      S_MG_CHK: begin
        nxt_nxt = nx_rdata;
        if ((bud < pool_end) && (tag_rdata == TAG_FREE) && (lvl_rdata == k_r)) begin
          nx_raddr  = PW'(bud);
          state_nxt = S_MG_NB;
        end else begin
          cur_nxt   = nx_rdata;
          state_nxt = S_MG_CUR;
        end
      end

      S_MG_NB: begin
        // the walk must skip the buddy when it is next in line
        if (EW'(nxt_r) == bud) begin
          nxt_nxt = nx_rdata;
        end
        ul_pg_nxt   = PW'(cur_r);
        ul_lvl_nxt  = k_r;
        sub_ret_nxt = S_MG_U2;
        state_nxt   = S_UL0;
      end

      S_MG_U2: begin
        ul_pg_nxt   = PW'(bud);
        sub_ret_nxt = S_MG_FIN;
        state_nxt   = S_UL0;
      end

      S_MG_FIN: begin
        lvl_we      = 1'b1;
        lvl_waddr   = PW'(lo);
        lvl_wdata   = k_r + LVW'(1);
        tag_we      = 1'b1;
        tag_waddr   = PW'(hi);
        tag_wdata   = TAG_PART;
        sp_pg_nxt   = PW'(lo);
        sp_lvl_nxt  = k_r + LVW'(1);
        cur_nxt     = nxt_r;
        sub_ret_nxt = S_MG_CUR;
        state_nxt   = S_PU0;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pool_r      <= CFG_W'(4096);
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= NIL;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        pool_r <= cfg_pool_pages;
      end
      if (hd_clr) begin
        for (int i = 0; i < LEVELS; i++) begin
          head_r[i] <= NIL;
        end
      end else if (hd_we) begin
        head_r[hd_widx] <= hd_wdata;
      end
    end
    sub_ret_r    <= sub_ret_nxt;
    cv_ret_r     <= cv_ret_nxt;
    op_r         <= op_nxt;
    req_r        <= req_nxt;
    pages_r      <= pages_nxt;
    partial_r    <= partial_nxt;
    p_r          <= p_nxt;
    k_r          <= k_nxt;
    merged_r     <= merged_nxt;
    sp_pg_r      <= sp_pg_nxt;
    sp_lvl_r     <= sp_lvl_nxt;
    h_r          <= h_nxt;
    ul_pg_r      <= ul_pg_nxt;
    ul_lvl_r     <= ul_lvl_nxt;
    cv_pg_r      <= cv_pg_nxt;
    cv_end_r     <= cv_end_nxt;
    cv_stop_r    <= cv_stop_nxt;
    cv_first_r   <= cv_first_nxt;
    cv_rest_r    <= cv_rest_nxt;
    cur_r        <= cur_nxt;
    nxt_r        <= nxt_nxt;
    fr_lvl_r     <= fr_lvl_nxt;
    fr_used_r    <= fr_used_nxt;
    res_page_r   <= res_page_nxt;
    res_status_r <= res_status_nxt;
  end

endmodule
`default_nettype wire

[rtl/bpa_checker.sv]
`default_nettype none
module bpa_props
  import bpa_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire logic [PAGE_W-1:0]   out_block_page,
  input wire logic [STATUS_W-1:0] out_status
);

  // every accepted beat raises busy in the cycle after it
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // the result beat comes out exactly when the block goes idle
  a_result_on_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result beat");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !$past(out_valid)))
    else $error("result beat while busy or repeated");

  a_fail_zero_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_block_page == '0))
    else $error("failed alloc returned a page");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == ST_OK) || (out_status == ST_TOO_BIG) ||
                   (out_status == ST_NO_BLOCK)))
    else $error("undefined status code");

endmodule

bind buddy_page_allocator_core bpa_props u_bpa_props (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_valid(out_valid),
  .out_block_page(out_block_page),
  .out_status(out_status)
);
`default_nettype wire

[bench/bpa_checker.sv]
`timescale 1ns / 1ps
module bpa_checker
  import bpa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [OPC_W-1:0]    in_opcode,
  input  wire logic [SLOG_W-1:0]   in_size_log,
  input  wire logic [BYTE_W-1:0]   in_byte_size,
  input  wire logic [PAGE_W-1:0]   in_page_index,
  input  wire logic                out_valid,
  input  wire logic [PAGE_W-1:0]   out_block_page,
  input  wire logic [STATUS_W-1:0] out_status,
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_W-1:0]    cfg_pool_pages,
  output int                       fail_count,
  output int                       pending
);
  localparam int NP   = BPA_NUM_PAGES;
  localparam int NLVL = BPA_LEVELS;
  localparam int PSL  = BPA_PAGE_SIZE_LOG;
  localparam int NONE = NP;

  typedef struct packed {
    logic [PAGE_W-1:0]   block_page;
    logic [STATUS_W-1:0] status;
  } alloc_result_t;

  alloc_result_t expected_results[$];

  int unsigned     pool_size;
  logic [TAG_W-1:0] tag_of[NP];
  int unsigned     level_of[NP];
  int unsigned     used_of[NP];
  int unsigned     next_of[NP];
  int unsigned     prev_of[NP];
  int unsigned     free_head[NLVL];

  function automatic int unsigned pool_limit();
    return (pool_size > NP) ? NP : pool_size;
  endfunction

  function automatic void push_free(int unsigned pg, int unsigned lvl);
    int unsigned h;
    h = free_head[lvl];
    next_of[pg] = h;
    prev_of[pg] = NONE;
    if (h != NONE) prev_of[h] = pg;
    free_head[lvl] = pg;
  endfunction

  function automatic void unlink_free(int unsigned pg, int unsigned lvl);
    int unsigned n, p;
    n = next_of[pg];
    p = prev_of[pg];
    if (p == NONE) free_head[lvl] = n;
    else next_of[p] = n;
    if (n != NONE) prev_of[n] = p;
  endfunction

  // cover [lo, hi) with maximal aligned blocks
  function automatic void carve_range(int unsigned lo, int unsigned hi,
                                      logic [TAG_W-1:0] head_tag,
                                      logic [TAG_W-1:0] rest_tag);
    int unsigned pg, sz;
    int k;
    pg = lo;
    if (hi > NP) hi = NP;
    while (pg < hi) begin
      sz = 1;
      for (k = NLVL - 1; k > 0; k--) begin
        sz = 1 << k;
        if ((pg & (sz - 1)) == 0 && pg + sz <= hi) break;
      end
      if (k == 0) sz = 1;
      tag_of[pg] = head_tag;
      level_of[pg] = k;
      if (head_tag == TAG_FREE) push_free(pg, k);
      for (int unsigned q = pg + 1; q < pg + sz; q++) tag_of[q] = rest_tag;
      pg += sz;
    end
  endfunction

  function automatic int unsigned lowest_nonempty(int unsigned from);
    for (int unsigned k = from; k < NLVL; k++)
      if (free_head[k] != NONE) return k;
    return NLVL;
  endfunction

  function automatic void merge_all_buddies();
    int unsigned lim, cur, nxt, bud, lo, hi;
    lim = pool_limit();
    for (int unsigned k = 0; k + 1 < NLVL; k++) begin
      cur = free_head[k];
      while (cur != NONE) begin
        nxt = next_of[cur];
        bud = cur ^ (1 << k);
        if (bud < lim && tag_of[bud] == TAG_FREE && level_of[bud] == k) begin
          lo = (cur < bud) ? cur : bud;
          hi = (cur < bud) ? bud : cur;
          if (nxt == bud) nxt = next_of[bud];
          unlink_free(cur, k);
          unlink_free(bud, k);
          level_of[lo] = k + 1;
          tag_of[hi] = TAG_PART;
          push_free(lo, k + 1);
        end
        cur = nxt;
      end
    end
  endfunction

  function automatic logic [STATUS_W-1:0] take_block(int unsigned req, output int unsigned pg);
    int unsigned k, half;
    pg = 0;
    k = lowest_nonempty(req);
    if (k >= NLVL) begin
      merge_all_buddies();
      k = lowest_nonempty(req);
      if (k >= NLVL) return ST_NO_BLOCK;
    end
    pg = free_head[k];
    unlink_free(pg, k);
    for (; k > req; k--) begin
      half = pg + (1 << (k - 1));
      push_free(half, k - 1);
      tag_of[half] = TAG_FREE;
      level_of[half] = k - 1;
    end
    tag_of[pg] = TAG_ALLOC;
    level_of[pg] = req;
    used_of[pg] = 1 << req;
    return ST_OK;
  endfunction

  function automatic void release_block(int unsigned p);
    int unsigned lvl, dlvl, half, used;
    if (p >= NP || tag_of[p] != TAG_ALLOC) return;
    lvl = level_of[p];
    if (lvl >= NLVL) lvl = NLVL - 1;
    dlvl = lvl;
    if (lvl >= 1) begin
      half = p + (1 << (lvl - 1));
      if (half < NP && tag_of[half] == TAG_PART_ALLOC) begin
        used = used_of[p];
        if (used > (1 << lvl)) used = 1 << lvl;
        dlvl = lvl - 1;
        level_of[p] = dlvl;
        carve_range(half, p + used, TAG_FREE, TAG_PART);
      end
    end
    tag_of[p] = TAG_FREE;
    push_free(p, dlvl);
  endfunction

  function automatic alloc_result_t predict_alloc(logic [OPC_W-1:0] op, int unsigned slog,
                                                  int unsigned nbytes, int unsigned pidx);
    alloc_result_t r;
    int unsigned pg, req, pages, lvl;
    pg = 0;
    r.status = ST_OK;
    if (op == OP_ALLOC_LOG) begin
      req = (slog < PSL) ? 0 : slog - PSL;
      if (req >= NLVL) r.status = ST_TOO_BIG;
      else r.status = take_block(req, pg);
    end else if (op == OP_ALLOC_BYTES) begin
      pages = (nbytes + (1 << PSL) - 1) >> PSL;
      if (pages == 0) pages = 1;
      lvl = 0;
      while (lvl < 31 && (1 << lvl) < pages) lvl++;
      if (lvl >= NLVL) r.status = ST_TOO_BIG;
      else begin
        r.status = take_block(lvl, pg);
        if (r.status == ST_OK) begin
          used_of[pg] = pages;
          if (pages < (1 << lvl)) begin
            carve_range(pg + (1 << (lvl - 1)), pg + pages, TAG_PART_ALLOC, TAG_PART_ALLOC);
            carve_range(pg + pages, pg + (1 << lvl), TAG_FREE, TAG_PART);
          end
        end
      end
    end else if (op == OP_FREE) begin
      release_block(pidx);
    end else begin
      for (int k = 0; k < NLVL; k++) free_head[k] = NONE;
      for (int q = 0; q < NP; q++) begin
        tag_of[q] = TAG_UNUSABLE;
        level_of[q] = 0;
      end
      carve_range(0, pool_limit(), TAG_FREE, TAG_PART);
    end
    if (r.status != ST_OK) pg = 0;
    r.block_page = pg[PAGE_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pool_size = NP;
    for (int k = 0; k < NLVL; k++) free_head[k] = NONE;
  end

  assign pending = expected_results.size();

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      pool_size = NP;
      for (int k = 0; k < NLVL; k++) free_head[k] = NONE;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat, page", out_block_page, -1);
        end else begin
          want = expected_results.pop_front();
          if (out_block_page !== want.block_page)
            report_mismatch("block_page", out_block_page, want.block_page);
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
        end
      end
      if (start && !busy)
        expected_results.push_back(predict_alloc(in_opcode, in_size_log,
                                                 in_byte_size, in_page_index));
      if (cfg_wr_en) pool_size = cfg_pool_pages;
    end
  end
endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import bpa_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OPC_W-1:0]    in_opcode;
  logic [SLOG_W-1:0]   in_size_log;
  logic [BYTE_W-1:0]   in_byte_size;
  logic [PAGE_W-1:0]   in_page_index;
  logic                out_valid;
  logic [PAGE_W-1:0]   out_block_page;
  logic [STATUS_W-1:0] out_status;
  logic                cfg_wr_en;
  logic [CFG_W-1:0]    cfg_pool_pages;
  int                  fail_count;
  int                  pending;

  logic [PAGE_W-1:0] held_pages[$];
  int                beat_count;
  bit                no_idle;

  buddy_page_allocator_core dut (.*);

  bpa_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // remember granted blocks so frees mostly hit real allocations
  always @(posedge clk) begin
    if (out_valid && out_status == ST_OK && out_block_page != 0) begin
      held_pages.push_back(out_block_page);
      if (held_pages.size() > 64) void'(held_pages.pop_front());
    end
  end

  task automatic send_req(logic [OPC_W-1:0] op, logic [SLOG_W-1:0] slog,
                          logic [BYTE_W-1:0] nbytes, logic [PAGE_W-1:0] pidx);
    start <= 1'b1;
    in_opcode <= op;
    in_size_log <= slog;
    in_byte_size <= nbytes;
    in_page_index <= pidx;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    beat_count++;
    if (!no_idle && $urandom_range(99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic free_some_held();
    int idx;
    idx = $urandom_range(held_pages.size() - 1);
    send_req(OP_FREE, 0, 0, held_pages[idx]);
    held_pages.delete(idx);
  endtask

  task automatic send_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      if ($urandom_range(9) < 8) send_req(OP_ALLOC_LOG, SLOG_W'($urandom_range(17, 10)), 0, 0);
      else send_req(OP_ALLOC_LOG, SLOG_W'($urandom), 0, 0);
    end else if (pick < 60) begin
      if ($urandom_range(9) < 8) send_req(OP_ALLOC_BYTES, 0, BYTE_W'($urandom_range(70000)), 0);
      else send_req(OP_ALLOC_BYTES, 0, BYTE_W'($urandom), 0);
    end else if (pick < 98) begin
      if (held_pages.size() > 0 && $urandom_range(9) < 8) free_some_held();
      else send_req(OP_FREE, 0, 0, PAGE_W'($urandom));
    end else begin
      held_pages.delete();
      send_req(OP_INIT, 0, 0, 0);
    end
  endtask

  // only while the block is idle: every result is in
  task automatic set_pool(int unsigned pages);
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_pool_pages <= CFG_W'(pages);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    held_pages.delete();
    send_req(OP_INIT, 0, 0, 0);
  endtask

  initial begin
    int unsigned pool_steps[7];
    pool_steps = '{4096, 1, 8191, 100, 3000, 37, 0};
    pool_steps[6] = $urandom_range(4096, 2);
    start = 1'b0;
    rst_n = 1'b0;
    in_opcode = OP_INIT;
    in_size_log = '0;
    in_byte_size = '0;
    in_page_index = '0;
    cfg_wr_en = 1'b0;
    cfg_pool_pages = '0;
    beat_count = 0;
    no_idle = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corner sizes, tails, bad frees, forced merge
    send_req(OP_INIT, 0, 0, 0);
    send_req(OP_ALLOC_LOG, 0, 0, 0);
    send_req(OP_ALLOC_LOG, 12, 0, 0);
    send_req(OP_ALLOC_LOG, 31, 0, 0);
    send_req(OP_ALLOC_LOG, 25, 0, 0);
    send_req(OP_ALLOC_BYTES, 0, 0, 0);
    send_req(OP_ALLOC_BYTES, 0, 1, 0);
    send_req(OP_ALLOC_BYTES, 0, 4097, 0);
    send_req(OP_ALLOC_BYTES, 0, 12289, 0);
    send_req(OP_ALLOC_BYTES, 0, 21000, 0);
    send_req(OP_ALLOC_BYTES, 0, '1, 0);
    send_req(OP_ALLOC_BYTES, 0, 16777216, 0);
    send_req(OP_FREE, 0, 0, 4095);
    send_req(OP_FREE, 0, 0, 3);
    set_pool(4096);
    send_req(OP_ALLOC_LOG, 24, 0, 0);
    send_req(OP_FREE, 0, 0, 0);
    send_req(OP_FREE, 0, 0, 0);
    send_req(OP_ALLOC_LOG, 12, 0, 0);
    send_req(OP_ALLOC_LOG, 12, 0, 0);
    send_req(OP_ALLOC_BYTES, 0, 12289, 0);
    set_pool(4096);
    while (held_pages.size() > 0) free_some_held();
    send_req(OP_ALLOC_LOG, 24, 0, 0);
    send_req(OP_INIT, 0, 0, 0);

    foreach (pool_steps[i]) begin
      set_pool(pool_steps[i]);
      for (int n = 0; n < 190; n++) begin
        no_idle = (i == 2);
        send_random();
      end
      no_idle = 1'b0;
    end
    start <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(60_000_000);
    $display("FAILED: results differ");
    $finish;
  end
endmodule

[files.f]
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_blk_size.sv
rtl/buddy_page_allocator_core.sv
rtl/bpa_checker.sv
bench/bpa_checker.sv
bench/testbench.sv
